[rtl/idwc_pkg.sv]
// ----------------------------------------------------------------------------
// idwc_pkg
// Shared types, codes and reset values of the drip warmer controller.
// ----------------------------------------------------------------------------
package idwc_pkg;

    // event kinds
    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_TEMP = 2'd1;
    localparam logic [1:0] OP_RATE = 2'd2;

    // key codes
    localparam logic [2:0] KEY_NONE = 3'd0;
    localparam logic [2:0] KEY_PAGE = 3'd1;
    localparam logic [2:0] KEY_UP   = 3'd2;
    localparam logic [2:0] KEY_DOWN = 3'd3;
    localparam logic [2:0] KEY_RUN  = 3'd4;

    // pages
    localparam logic [1:0] PAGE_START    = 2'd0;
    localparam logic [1:0] PAGE_MONITOR  = 2'd1;
    localparam logic [1:0] PAGE_SET_RATE = 2'd2;
    localparam logic [1:0] PAGE_SET_TEMP = 2'd3;

    // motor command codes
    localparam logic [1:0] MOTOR_NONE   = 2'd0;
    localparam logic [1:0] MOTOR_ROTATE = 2'd1;
    localparam logic [1:0] MOTOR_HALT   = 2'd2;

    localparam logic [1:0] ANGLE_FINE   = 2'd0;
    localparam logic [1:0] ANGLE_MID    = 2'd1;
    localparam logic [1:0] ANGLE_COARSE = 2'd2;
    localparam logic [1:0] ANGLE_JOG    = 2'd3;

    localparam logic [2:0] SPEED_AUTO = 3'd2;
    localparam logic [2:0] SPEED_JOG  = 3'd4;

    // setpoint step thresholds (temperature in half degrees); setpoints stay within 40..70 and 20..60
    localparam logic [6:0] TEMP_UP_MAX   = 7'd69;
    localparam logic [6:0] TEMP_DOWN_MIN = 7'd41;
    localparam logic [5:0] RATE_UP_MAX   = 6'd59;
    localparam logic [5:0] RATE_DOWN_MIN = 6'd21;

    // reset values
    localparam logic [6:0] TEMP_RESET   = 7'd50;
    localparam logic [5:0] RATE_RESET   = 6'd40;
    localparam logic [7:0] HYST_RESET   = 8'd20;
    localparam logic [5:0] DEAD_RESET   = 6'd2;
    localparam logic [5:0] FINE_RESET   = 6'd5;
    localparam logic [6:0] COARSE_RESET = 7'd20;
    localparam logic [7:0] MAX_RESET    = 8'd60;

    // register indexes on the config port
    localparam logic [2:0] REG_HYST   = 3'd0;
    localparam logic [2:0] REG_DEAD   = 3'd1;
    localparam logic [2:0] REG_FINE   = 3'd2;
    localparam logic [2:0] REG_COARSE = 3'd3;
    localparam logic [2:0] REG_MAX    = 3'd4;

    typedef struct packed {
        logic [7:0] hysteresis_tenths;
        logic [5:0] dead_band;
        logic [5:0] fine_band;
        logic [6:0] coarse_band;
        logic [7:0] max_band;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         key_code;
        logic signed [11:0] temp_tenths;
        logic [9:0]         drip_rate;
        logic               timer_flag;
    } event_t;

    typedef struct packed {
        logic [1:0] page;
        logic [6:0] target_temp_half;
        logic [5:0] target_rate;
        logic       running;
        logic       heater_on;
        logic [1:0] motor_action;
        logic       motor_dir;
        logic [1:0] motor_angle_code;
        logic [2:0] motor_speed;
        logic       motor_manual;
    } result_t;

endpackage

[rtl/infusion_drip_warmer_controller_core.sv]
// ----------------------------------------------------------------------------
// infusion_drip_warmer_controller_core
// Event-driven drip warmer controller: keys, heater relay, stepper commands.
// ----------------------------------------------------------------------------
// Input stream s_*: one event word per beat, kind in s_axis_tuser (opcode),
// key/temperature/rate/timer fields in s_axis_tdata.
// Output stream m_*: exactly one result word per event, in order, carrying
// page, setpoints, run and relay state after the event plus the motor
// command that the event caused.
// Path: each event passes the input register, then the result register;
// a held result stays valid until it is taken.
// Throughput: one event per cycle while the result stream is not stalled;
// the state update of an event is visible to the next event in the following cycle.
// Stall: while m_axis_tready is low and a result is held, the input register
// keeps its word and s_axis_tready drops once it is full; no word is lost.
// Reset (aresetn low, synchronous): both stages empty, page 0, target 25.0 C,
// target rate 40, run off, relay off, band registers at their defaults.
// Config: APB writes with pready always high; write only while idle.
// ----------------------------------------------------------------------------
module infusion_drip_warmer_controller_core (
    input  logic        aclk,
    input  logic        aresetn,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // key_code[2:0], temp_tenths[14:3],
                                       // drip_rate[24:15], timer_flag[25]
    input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // page[1:0], target_temp_half[8:2],
                                       // target_rate[14:9], running[15],
                                       // heater_on[16], motor_action[18:17],
                                       // motor_dir[19], motor_angle_code[21:20],
                                       // motor_speed[24:22], motor_manual[25]
);

    idwc_pkg::cfg_t    cfg;
    idwc_pkg::event_t  evt_reg;
    idwc_pkg::result_t res;
    idwc_pkg::result_t res_reg;

    logic evt_valid_reg;
    logic out_valid_reg;
    logic advance;
    logic fire;

    idwc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = evt_valid_reg && advance;
    assign s_axis_tready = !evt_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            evt_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            evt_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            evt_reg.opcode      <= s_axis_tuser;
            evt_reg.key_code    <= s_axis_tdata[2:0];
            evt_reg.temp_tenths <= s_axis_tdata[14:3];
            evt_reg.drip_rate   <= s_axis_tdata[24:15];
            evt_reg.timer_flag  <= s_axis_tdata[25];
        end
    end

    idwc_event_logic u_logic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .evt     (evt_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= evt_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            res_reg.motor_manual,
                            res_reg.motor_speed,
                            res_reg.motor_angle_code,
                            res_reg.motor_dir,
                            res_reg.motor_action,
                            res_reg.heater_on,
                            res_reg.running,
                            res_reg.target_rate,
                            res_reg.target_temp_half,
                            res_reg.page};

endmodule

[rtl/idwc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// idwc_cfg_regs
// APB register file for the hysteresis and motor band settings.
// ----------------------------------------------------------------------------
module idwc_cfg_regs (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output idwc_pkg::cfg_t   cfg
);

    idwc_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite & pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hysteresis_tenths <= idwc_pkg::HYST_RESET;
            cfg_reg.dead_band         <= idwc_pkg::DEAD_RESET;
            cfg_reg.fine_band         <= idwc_pkg::FINE_RESET;
            cfg_reg.coarse_band       <= idwc_pkg::COARSE_RESET;
            cfg_reg.max_band          <= idwc_pkg::MAX_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                idwc_pkg::REG_HYST:   cfg_reg.hysteresis_tenths <= pwdata[7:0];
                idwc_pkg::REG_DEAD:   cfg_reg.dead_band         <= pwdata[5:0];
                idwc_pkg::REG_FINE:   cfg_reg.fine_band         <= pwdata[5:0];
                idwc_pkg::REG_COARSE: cfg_reg.coarse_band       <= pwdata[6:0];
                idwc_pkg::REG_MAX:    cfg_reg.max_band          <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            idwc_pkg::REG_HYST:   prdata = {24'd0, cfg_reg.hysteresis_tenths};
            idwc_pkg::REG_DEAD:   prdata = {26'd0, cfg_reg.dead_band};
            idwc_pkg::REG_FINE:   prdata = {26'd0, cfg_reg.fine_band};
            idwc_pkg::REG_COARSE: prdata = {25'd0, cfg_reg.coarse_band};
            idwc_pkg::REG_MAX:    prdata = {24'd0, cfg_reg.max_band};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

[rtl/idwc_event_logic.sv]
// ----------------------------------------------------------------------------
// idwc_event_logic
// Controller state and the per-event decision logic (keys, relay, motor).
// ----------------------------------------------------------------------------
module idwc_event_logic (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  idwc_pkg::event_t  evt,
    input  idwc_pkg::cfg_t    cfg,
    output idwc_pkg::result_t res
);

    logic [1:0] page_reg,  page_next;
    logic [6:0] temp_reg,  temp_next;
    logic [5:0] rate_reg,  rate_next;
    logic       run_reg,   run_next;
    logic       relay_reg, relay_next;

    logic [1:0] act;
    logic       dir;
    logic [1:0] ang;
    logic [2:0] spd;
    logic       man;

    // temperature compare: target*5 vs sample, 14-bit signed
    logic signed [13:0] tgt_tenths;
    logic signed [13:0] below;
    logic signed [13:0] above;
    logic signed [13:0] hys;

    // rate error
    logic signed [10:0] err;
    logic [9:0]         mag;

    assign tgt_tenths = signed'({7'd0, temp_reg} * 14'd5);
    assign below      = tgt_tenths - 14'(evt.temp_tenths);
    assign above      = 14'(evt.temp_tenths) - tgt_tenths;
    assign hys        = signed'({6'd0, cfg.hysteresis_tenths});

    assign err = signed'({1'b0, evt.drip_rate}) - signed'({5'd0, rate_reg});
    assign mag = err[10] ? 10'(-err) : err[9:0];

    always_comb begin
        page_next  = page_reg;
        temp_next  = temp_reg;
        rate_next  = rate_reg;
        run_next   = run_reg;
        relay_next = relay_reg;
        act = idwc_pkg::MOTOR_NONE;
        dir = 1'b0;
        ang = idwc_pkg::ANGLE_FINE;
        spd = 3'd0;
        man = 1'b0;

        case (evt.opcode)
            idwc_pkg::OP_KEY: begin
                case (evt.key_code)
                    idwc_pkg::KEY_PAGE: begin
                        page_next = (page_reg == idwc_pkg::PAGE_SET_TEMP)
                                  ? idwc_pkg::PAGE_MONITOR : page_reg + 2'd1;
                    end
                    idwc_pkg::KEY_UP, idwc_pkg::KEY_DOWN: begin
                        if (page_reg == idwc_pkg::PAGE_SET_TEMP) begin
                            if (evt.key_code == idwc_pkg::KEY_UP) begin
                                if (temp_reg <= idwc_pkg::TEMP_UP_MAX)
                                    temp_next = temp_reg + 7'd1;
                            end else if (temp_reg >= idwc_pkg::TEMP_DOWN_MIN) begin
                                temp_next = temp_reg - 7'd1;
                            end
                        end else if (page_reg == idwc_pkg::PAGE_SET_RATE) begin
                            if (evt.key_code == idwc_pkg::KEY_UP) begin
                                if (rate_reg <= idwc_pkg::RATE_UP_MAX)
                                    rate_next = rate_reg + 6'd1;
                            end else if (rate_reg >= idwc_pkg::RATE_DOWN_MIN) begin
                                rate_next = rate_reg - 6'd1;
                            end
                        end else if (page_reg == idwc_pkg::PAGE_MONITOR && !run_reg) begin
                            // manual jog while stopped
                            act = idwc_pkg::MOTOR_ROTATE;
                            dir = (evt.key_code == idwc_pkg::KEY_UP);
                            ang = idwc_pkg::ANGLE_JOG;
                            spd = idwc_pkg::SPEED_JOG;
                            man = 1'b1;
                        end
                    end
                    idwc_pkg::KEY_RUN: begin
                        if (page_reg == idwc_pkg::PAGE_MONITOR)
                            run_next = ~run_reg;
                    end
                    default: ;
                endcase
            end
            idwc_pkg::OP_TEMP: begin
                if (below > hys) relay_next = 1'b1;
                if (above > hys) relay_next = 1'b0;
            end
            idwc_pkg::OP_RATE: begin
                if (evt.timer_flag) begin
                    // gears tested low to high, so overlapping bands pick the lowest
                    if (mag <= {4'd0, cfg.dead_band}) begin
                        act = idwc_pkg::MOTOR_HALT;
                    end else begin
                        act = idwc_pkg::MOTOR_ROTATE;
                        dir = (err > 11'sd0);
                        spd = idwc_pkg::SPEED_AUTO;
                        if (mag <= {4'd0, cfg.fine_band}) begin
                            ang = idwc_pkg::ANGLE_FINE;
                        end else if (mag <= {3'd0, cfg.coarse_band}) begin
                            ang = idwc_pkg::ANGLE_MID;
                        end else if (mag <= {2'd0, cfg.max_band}) begin
                            ang = idwc_pkg::ANGLE_COARSE;
                        end else begin
                            act = idwc_pkg::MOTOR_NONE;
                            dir = 1'b0;
                            spd = 3'd0;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_reg  <= idwc_pkg::PAGE_START;
            temp_reg  <= idwc_pkg::TEMP_RESET;
            rate_reg  <= idwc_pkg::RATE_RESET;
            run_reg   <= 1'b0;
            relay_reg <= 1'b0;
        end else if (fire) begin
            page_reg  <= page_next;
            temp_reg  <= temp_next;
            rate_reg  <= rate_next;
            run_reg   <= run_next;
            relay_reg <= relay_next;
        end
    end

    always_comb begin
        res.page             = page_next;
        res.target_temp_half = temp_next;
        res.target_rate      = rate_next;
        res.running          = run_next;
        res.heater_on        = relay_next;
        res.motor_action     = act;
        res.motor_dir        = dir;
        res.motor_angle_code = ang;
        res.motor_speed      = spd;
        res.motor_manual     = man;
    end

endmodule
